// ----- src/spe_pkg.sv -----
package spe_pkg;

   // Receive framing
   localparam int MAX_FRAME_BYTES = 64;
   localparam int RX_COUNT_W      = $clog2(MAX_FRAME_BYTES);
   localparam int RX_POS_ERROR    = 2;
   localparam int RX_POS_PARAM_LO = 3;
   localparam int RX_POS_PARAM_HI = 4;

   // Transmit framing: FF FF id len instr p0 p1 p2 checksum
   localparam int FRAME_BYTES = 9;
   localparam int FRAME_CNT_W = $clog2(FRAME_BYTES);

   // Request kinds
   localparam logic [2:0] KIND_WR_POS    = 3'd0;
   localparam logic [2:0] KIND_WR_SPEED  = 3'd1;
   localparam logic [2:0] KIND_RD_POS    = 3'd2;
   localparam logic [2:0] KIND_RD_SPEED  = 3'd3;
   localparam logic [2:0] KIND_RD_TEMP   = 3'd4;
   localparam logic [2:0] KIND_RX_BYTE   = 3'd5;

   // Result kinds
   localparam logic OUT_TX_BYTE = 1'b0;
   localparam logic OUT_REPLY   = 1'b1;

   // Reply field codes
   localparam logic [1:0] FIELD_NONE  = 2'd0;
   localparam logic [1:0] FIELD_POS   = 2'd1;
   localparam logic [1:0] FIELD_SPEED = 2'd2;
   localparam logic [1:0] FIELD_TEMP  = 2'd3;

   // Register indexes
   localparam logic [1:0] CSR_CLAMP_ID = 2'd0;
   localparam logic [1:0] CSR_FLOOR    = 2'd1;
   localparam logic [1:0] CSR_CEILING  = 2'd2;

   // Protocol bytes
   localparam logic [7:0] HDR_BYTE           = 8'hFF;
   localparam logic [7:0] INSTR_WRITE        = 8'h03;
   localparam logic [7:0] INSTR_READ         = 8'h02;
   localparam logic [7:0] ADDR_GOAL_POS      = 8'h1E;
   localparam logic [7:0] ADDR_MOVING_SPEED  = 8'h20;
   localparam logic [7:0] ADDR_PRESENT_POS   = 8'h24;
   localparam logic [7:0] ADDR_PRESENT_SPEED = 8'h26;
   localparam logic [7:0] ADDR_PRESENT_TEMP  = 8'h2B;
   localparam logic [7:0] LEN_WRITE          = 8'h05;
   localparam logic [7:0] LEN_READ           = 8'h04;
   localparam logic [7:0] RD_LEN_WORD        = 8'h02;
   localparam logic [7:0] RD_LEN_BYTE        = 8'h01;
   localparam logic [15:0] POS_MAX           = 16'h0FFF;
   localparam logic [15:0] SPEED_MAX         = 16'h03FF;

   typedef struct packed {
      logic [7:0]  clamp_id;
      logic [11:0] floor;
      logic [11:0] ceiling;
   } cfg_type;

   typedef struct packed {
      logic                               valid;
      logic [FRAME_CNT_W-1:0]             last;
      logic [FRAME_BYTES-1:0][7:0]        bytes;
   } frame_type;

   typedef struct packed {
      logic        valid;
      logic [1:0]  field;
      logic [15:0] value;
      logic [7:0]  error;
      logic        ok;
   } reply_type;

endpackage

// ----- src/servo_packet_engine_unit.sv -----
// Servo bus packet engine.
// Request channel (req_valid/req_ready): one request per accept. Command kinds
// (write position, write speed, read position/speed/temperature) become one
// framed instruction packet: FF FF id len instr params checksum, 9 bytes for
// writes and 8 for reads. Received-byte requests feed the status checker; the
// byte flagged final yields one decoded reply, other bytes yield nothing.
// Response channel (rsp_valid/rsp_ready): one packet byte or one reply per
// transfer; rsp_last_of_run marks the last byte of a packet and every reply.
// Config channel (csr_valid/csr_ready): always ready; write only while idle.
// The first result passes the run buffer, then the response register, to the port.
// Throughput: a command holds the request channel until its packet (8 or 9 bytes)
// drains, one byte per cycle while the receiver does not stall; received bytes are
// taken every cycle while the run buffer is empty or emptying. The run buffer and the
// response register are separate, so the next request is taken while a result waits.
// Reset: synchronous; clears the run buffer, response valid, receive state
// and loads the register defaults (clamp id 1, window 0..4095).
// Receiver stall: the response register holds, the run buffer holds, and
// req_ready drops once the run buffer is occupied.
module servo_packet_engine_unit
   import spe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_kind,
   input  logic [7:0]  req_servo_id,
   input  logic [15:0] req_target_value,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_rx_final,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_out_kind,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_last_of_run,
   output logic [1:0]  rsp_reply_field,
   output logic [15:0] rsp_reply_value,
   output logic [7:0]  rsp_servo_error,
   output logic        rsp_checksum_ok,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [11:0] csr_data
);

   cfg_type   cfg_ff, cfg_in;
   frame_type frame;
   reply_type reply;

   // Run buffer: a packet being shifted out, or a single reply
   logic                        run_active_ff, run_active_in;
   logic                        run_reply_ff, run_reply_in;
   logic [FRAME_BYTES-1:0][7:0] run_bytes_ff, run_bytes_in;
   logic [FRAME_CNT_W-1:0]      run_left_ff, run_left_in;
   reply_type                   run_data_ff, run_data_in;

   // Response register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_kind_ff, rsp_kind_in;
   logic [7:0]  rsp_byte_ff, rsp_byte_in;
   logic        rsp_last_ff, rsp_last_in;
   logic [1:0]  rsp_field_ff, rsp_field_in;
   logic [15:0] rsp_value_ff, rsp_value_in;
   logic [7:0]  rsp_error_ff, rsp_error_in;
   logic        rsp_ok_ff, rsp_ok_in;

   logic out_advance;
   logic run_pop;
   logic run_done;
   logic req_fire;

   spe_frame u_frame (
      .kind         (req_kind),
      .servo_id     (req_servo_id),
      .target_value (req_target_value),
      .cfg          (cfg_ff),
      .frame        (frame)
   );

   spe_rx u_rx (
      .clock    (clock),
      .reset    (reset),
      .accept   (req_fire),
      .kind     (req_kind),
      .rx_byte  (req_rx_byte),
      .rx_final (req_rx_final),
      .reply    (reply)
   );

   // Handshake: take a request when the run buffer is empty or empties this cycle
   assign out_advance = !rsp_valid_ff || rsp_ready;
   assign run_pop     = run_active_ff && out_advance;
   assign run_done    = run_pop && (run_reply_ff || (run_left_ff == '0));
   assign req_ready   = !run_active_ff || run_done;
   assign req_fire    = req_valid && req_ready;
   assign csr_ready   = 1'b1;

   // Register writes; unknown indexes drop
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_CLAMP_ID: cfg_in.clamp_id = csr_data[7:0];
            CSR_FLOOR:    cfg_in.floor    = csr_data;
            CSR_CEILING:  cfg_in.ceiling  = csr_data;
            default: begin
            end
         endcase
      end
   end

   // Run buffer: advance on pop, load on a request that has results
   always_comb begin
      run_active_in = run_active_ff;
      run_reply_in  = run_reply_ff;
      run_bytes_in  = run_bytes_ff;
      run_left_in   = run_left_ff;
      run_data_in   = run_data_ff;
      if (run_pop) begin
         if (run_done) begin
            run_active_in = 1'b0;
         end else begin
            for (int i = 0; i < FRAME_BYTES - 1; i++) begin
               run_bytes_in[i] = run_bytes_ff[i+1];
            end
            run_bytes_in[FRAME_BYTES-1] = 8'h00;
            run_left_in = run_left_ff - FRAME_CNT_W'(1);
         end
      end
      if (req_fire && frame.valid) begin
         run_active_in = 1'b1;
         run_reply_in  = 1'b0;
         run_bytes_in  = frame.bytes;
         run_left_in   = frame.last;
      end else if (req_fire && reply.valid) begin
         run_active_in = 1'b1;
         run_reply_in  = 1'b1;
         run_data_in   = reply;
      end
   end

   // Response register: hold while stalled, else take the run head
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_field_in = rsp_field_ff;
      rsp_value_in = rsp_value_ff;
      rsp_error_in = rsp_error_ff;
      rsp_ok_in    = rsp_ok_ff;
      if (out_advance) begin
         rsp_valid_in = run_active_ff;
         if (run_reply_ff) begin
            rsp_kind_in  = OUT_REPLY;
            rsp_byte_in  = 8'h00;
            rsp_last_in  = 1'b1;
            rsp_field_in = run_data_ff.field;
            rsp_value_in = run_data_ff.value;
            rsp_error_in = run_data_ff.error;
            rsp_ok_in    = run_data_ff.ok;
         end else begin
            rsp_kind_in  = OUT_TX_BYTE;
            rsp_byte_in  = run_bytes_ff[0];
            rsp_last_in  = (run_left_ff == '0);
            rsp_field_in = FIELD_NONE;
            rsp_value_in = 16'h0000;
            rsp_error_in = 8'h00;
            rsp_ok_in    = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.clamp_id <= 8'h01;
         cfg_ff.floor    <= 12'h000;
         cfg_ff.ceiling  <= 12'hFFF;
         run_active_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         cfg_ff          <= cfg_in;
         run_active_ff   <= run_active_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      run_reply_ff <= run_reply_in;
      run_bytes_ff <= run_bytes_in;
      run_left_ff  <= run_left_in;
      run_data_ff  <= run_data_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_field_ff <= rsp_field_in;
      rsp_value_ff <= rsp_value_in;
      rsp_error_ff <= rsp_error_in;
      rsp_ok_ff    <= rsp_ok_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_kind    = rsp_kind_ff;
   assign rsp_tx_byte     = rsp_byte_ff;
   assign rsp_last_of_run = rsp_last_ff;
   assign rsp_reply_field = rsp_field_ff;
   assign rsp_reply_value = rsp_value_ff;
   assign rsp_servo_error = rsp_error_ff;
   assign rsp_checksum_ok = rsp_ok_ff;

endmodule

// ----- src/spe_frame.sv -----
module spe_frame
   import spe_pkg::*;
(
   input  logic [2:0]  kind,
   input  logic [7:0]  servo_id,
   input  logic [15:0] target_value,
   input  cfg_type     cfg,
   output frame_type   frame
);

   logic [15:0] pos_win;
   logic [15:0] pos_val;
   logic [15:0] spd_val;
   logic [7:0]  len;
   logic [7:0]  instr;
   logic [7:0]  p0;
   logic [7:0]  p1;
   logic [7:0]  p2;
   logic [7:0]  sum;
   logic        is_write;

   // Ceiling first, floor second: floor wins on an inverted window
   always_comb begin
      pos_win = target_value;
      if (servo_id == cfg.clamp_id) begin
         if (pos_win > {4'h0, cfg.ceiling}) pos_win = {4'h0, cfg.ceiling};
         if (pos_win < {4'h0, cfg.floor})   pos_win = {4'h0, cfg.floor};
      end
      pos_val = (pos_win > POS_MAX) ? POS_MAX : pos_win;
      spd_val = (target_value > SPEED_MAX) ? SPEED_MAX : target_value;
   end

   always_comb begin
      frame.valid = 1'b1;
      is_write    = 1'b1;
      instr       = INSTR_WRITE;
      len         = LEN_WRITE;
      p0          = ADDR_GOAL_POS;
      p1          = pos_val[7:0];
      p2          = pos_val[15:8];
      case (kind)
         KIND_WR_POS: begin
         end
         KIND_WR_SPEED: begin
            p0 = ADDR_MOVING_SPEED;
            p1 = spd_val[7:0];
            p2 = spd_val[15:8];
         end
         KIND_RD_POS, KIND_RD_SPEED, KIND_RD_TEMP: begin
            is_write = 1'b0;
            instr    = INSTR_READ;
            len      = LEN_READ;
            p2       = 8'h00;
            case (kind)
               KIND_RD_POS:   begin p0 = ADDR_PRESENT_POS;   p1 = RD_LEN_WORD; end
               KIND_RD_SPEED: begin p0 = ADDR_PRESENT_SPEED; p1 = RD_LEN_WORD; end
               default:       begin p0 = ADDR_PRESENT_TEMP;  p1 = RD_LEN_BYTE; end
            endcase
         end
         default: begin
            frame.valid = 1'b0;
         end
      endcase

      sum = servo_id + len + instr + p0 + p1 + p2;

      frame.bytes[0] = HDR_BYTE;
      frame.bytes[1] = HDR_BYTE;
      frame.bytes[2] = servo_id;
      frame.bytes[3] = len;
      frame.bytes[4] = instr;
      frame.bytes[5] = p0;
      frame.bytes[6] = p1;
      if (is_write) begin
         frame.bytes[7] = p2;
         frame.bytes[8] = ~sum;
         frame.last     = FRAME_CNT_W'(FRAME_BYTES - 1);
      end else begin
         frame.bytes[7] = ~sum;
         frame.bytes[8] = 8'h00;
         frame.last     = FRAME_CNT_W'(FRAME_BYTES - 2);
      end
   end

endmodule

// ----- src/spe_rx.sv -----
module spe_rx
   import spe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [2:0] kind,
   input  logic [7:0] rx_byte,
   input  logic       rx_final,
   output reply_type  reply
);

   logic [7:0]            queried_addr_ff, queried_addr_in;
   logic [RX_COUNT_W-1:0] count_ff, count_in;
   logic [7:0]            sum_ff, sum_in;
   logic [7:0]            err_ff, err_in;
   logic [7:0]            lo_ff, lo_in;
   logic [7:0]            hi_ff, hi_in;

   // Decode reply from current state and the checksum byte
   always_comb begin
      reply.valid = (kind == KIND_RX_BYTE) && rx_final;
      reply.ok    = ((~sum_ff) == rx_byte);
      reply.field = FIELD_NONE;
      reply.value = 16'h0000;
      reply.error = 8'h00;
      if (reply.ok) begin
         reply.error = err_ff;
         case (queried_addr_ff)
            ADDR_PRESENT_POS: begin
               reply.field = FIELD_POS;
               reply.value = {hi_ff, lo_ff};
            end
            ADDR_PRESENT_SPEED: begin
               reply.field = FIELD_SPEED;
               reply.value = {hi_ff, lo_ff};
            end
            ADDR_PRESENT_TEMP: begin
               reply.field = FIELD_TEMP;
               reply.value = {8'h00, lo_ff};
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      queried_addr_in = queried_addr_ff;
      count_in        = count_ff;
      sum_in          = sum_ff;
      err_in          = err_ff;
      lo_in           = lo_ff;
      hi_in           = hi_ff;
      if (accept) begin
         case (kind)
            KIND_RD_POS:   queried_addr_in = ADDR_PRESENT_POS;
            KIND_RD_SPEED: queried_addr_in = ADDR_PRESENT_SPEED;
            KIND_RD_TEMP:  queried_addr_in = ADDR_PRESENT_TEMP;
            KIND_RX_BYTE: begin
               if (rx_final) begin
                  count_in = '0;
                  sum_in   = 8'h00;
                  err_in   = 8'h00;
                  lo_in    = 8'h00;
                  hi_in    = 8'h00;
               end else if (count_ff < RX_COUNT_W'(MAX_FRAME_BYTES - 1)) begin
                  if (count_ff == RX_COUNT_W'(RX_POS_ERROR))    err_in = rx_byte;
                  if (count_ff == RX_COUNT_W'(RX_POS_PARAM_LO)) lo_in  = rx_byte;
                  if (count_ff == RX_COUNT_W'(RX_POS_PARAM_HI)) hi_in  = rx_byte;
                  sum_in   = sum_ff + rx_byte;
                  count_in = count_ff + RX_COUNT_W'(1);
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         queried_addr_ff <= 8'h00;
         count_ff        <= '0;
         sum_ff          <= 8'h00;
         err_ff          <= 8'h00;
         lo_ff           <= 8'h00;
         hi_ff           <= 8'h00;
      end else begin
         queried_addr_ff <= queried_addr_in;
         count_ff        <= count_in;
         sum_ff          <= sum_in;
         err_ff          <= err_in;
         lo_ff           <= lo_in;
         hi_ff           <= hi_in;
      end
   end

endmodule

// ----- sim/servo_packet_engine_checker.sv -----
// Watches the request, response and register channels of the servo packet engine,
// forecasts every packet byte and status reply, and compares each response with
// the oldest forecast.
module servo_packet_engine_checker
   import spe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [2:0]  req_kind,
   input  logic [7:0]  req_servo_id,
   input  logic [15:0] req_target_value,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_rx_final,

   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_out_kind,
   input  logic [7:0]  rsp_tx_byte,
   input  logic        rsp_last_of_run,
   input  logic [1:0]  rsp_reply_field,
   input  logic [15:0] rsp_reply_value,
   input  logic [7:0]  rsp_servo_error,
   input  logic        rsp_checksum_ok,

   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [11:0] csr_data,

   output int          fail_count,
   output int          outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic        out_kind;
      logic [7:0]  tx_byte;
      logic        last;
      logic [1:0]  field;
      logic [15:0] value;
      logic [7:0]  error;
      logic        ok;
   } engine_rsp_type;

   engine_rsp_type packet_and_reply_q [$];

   // Register copies
   logic [7:0]  clamp_id_copy;
   logic [11:0] floor_copy;
   logic [11:0] ceiling_copy;

   // Status receive state
   logic [7:0]  query_addr;
   logic [6:0]  status_count;
   logic [7:0]  status_sum;
   logic [7:0]  status_error;
   logic [7:0]  status_param_lo;
   logic [7:0]  status_param_hi;

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

   task automatic clear_status();
      status_count    = '0;
      status_sum      = '0;
      status_error    = '0;
      status_param_lo = '0;
      status_param_hi = '0;
   endtask

   // Queue the framed instruction packet: FF FF id len instr params checksum.
   task automatic queue_frame(input logic [7:0] id, input logic [7:0] instr,
                              input logic [7:0] p0, input logic [7:0] p1,
                              input logic [7:0] p2, input int nparam);
      logic [7:0]     frame [9];
      logic [7:0]     sum;
      engine_rsp_type r;
      int             n;
      frame[0] = HDR_BYTE;
      frame[1] = HDR_BYTE;
      frame[2] = id;
      frame[3] = 8'(nparam + 2);
      frame[4] = instr;
      frame[5] = p0;
      frame[6] = p1;
      frame[7] = p2;
      n = 5 + nparam;
      sum = '0;
      for (int i = 2; i < n; i++) sum += frame[i];
      frame[n] = ~sum;
      for (int i = 0; i <= n; i++) begin
         r = '0;
         r.out_kind = OUT_TX_BYTE;
         r.tx_byte  = frame[i];
         r.last     = (i == n);
         packet_and_reply_q.push_back(r);
      end
   endtask

   task automatic forecast_request(input logic [2:0] kind, input logic [7:0] id,
                                   input logic [15:0] target, input logic [7:0] rx,
                                   input logic fin);
      logic [15:0]    goal;
      engine_rsp_type r;
      goal = target;
      case (kind)
         KIND_WR_POS: begin
            // ceiling first, floor second: floor wins on an inverted window
            if (id == clamp_id_copy) begin
               if (goal > {4'h0, ceiling_copy}) goal = {4'h0, ceiling_copy};
               if (goal < {4'h0, floor_copy}) goal = {4'h0, floor_copy};
            end
            if (goal > POS_MAX) goal = POS_MAX;
            queue_frame(id, INSTR_WRITE, ADDR_GOAL_POS, goal[7:0], goal[15:8], 3);
         end
         KIND_WR_SPEED: begin
            if (goal > SPEED_MAX) goal = SPEED_MAX;
            queue_frame(id, INSTR_WRITE, ADDR_MOVING_SPEED, goal[7:0], goal[15:8], 3);
         end
         KIND_RD_POS: begin
            query_addr = ADDR_PRESENT_POS;
            queue_frame(id, INSTR_READ, ADDR_PRESENT_POS, RD_LEN_WORD, 8'h00, 2);
         end
         KIND_RD_SPEED: begin
            query_addr = ADDR_PRESENT_SPEED;
            queue_frame(id, INSTR_READ, ADDR_PRESENT_SPEED, RD_LEN_WORD, 8'h00, 2);
         end
         KIND_RD_TEMP: begin
            query_addr = ADDR_PRESENT_TEMP;
            queue_frame(id, INSTR_READ, ADDR_PRESENT_TEMP, RD_LEN_BYTE, 8'h00, 2);
         end
         KIND_RX_BYTE: begin
            if (!fin) begin
               // bytes past the frame limit are dropped
               if (status_count < MAX_FRAME_BYTES - 1) begin
                  case (status_count)
                     7'(RX_POS_ERROR):    status_error    = rx;
                     7'(RX_POS_PARAM_LO): status_param_lo = rx;
                     7'(RX_POS_PARAM_HI): status_param_hi = rx;
                     default: ;
                  endcase
                  status_sum   = status_sum + rx;
                  status_count = status_count + 7'd1;
               end
            end else begin
               r = '0;
               r.out_kind = OUT_REPLY;
               r.last     = 1'b1;
               r.field    = FIELD_NONE;
               if (rx == ~status_sum) begin
                  r.ok    = 1'b1;
                  r.error = status_error;
                  case (query_addr)
                     ADDR_PRESENT_POS: begin
                        r.field = FIELD_POS;
                        r.value = {status_param_hi, status_param_lo};
                     end
                     ADDR_PRESENT_SPEED: begin
                        r.field = FIELD_SPEED;
                        r.value = {status_param_hi, status_param_lo};
                     end
                     ADDR_PRESENT_TEMP: begin
                        r.field = FIELD_TEMP;
                        r.value = {8'h00, status_param_lo};
                     end
                     default: ;
                  endcase
               end
               packet_and_reply_q.push_back(r);
               clear_status();
            end
         end
         default: ;
      endcase
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      engine_rsp_type want;
      if (reset) begin
         clamp_id_copy = 8'd1;
         floor_copy    = 12'd0;
         ceiling_copy  = 12'hFFF;
         query_addr    = '0;
         clear_status();
         packet_and_reply_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CLAMP_ID: clamp_id_copy = csr_data[7:0];
               CSR_FLOOR:    floor_copy    = csr_data;
               CSR_CEILING:  ceiling_copy  = csr_data;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (packet_and_reply_q.size() == 0) begin
               $error("response with nothing expected: kind %0d byte 0x%0h",
                      rsp_out_kind, rsp_tx_byte);
               fail_count++;
            end else begin
               want = packet_and_reply_q.pop_front();
               check_field("out_kind", 16'(want.out_kind), 16'(rsp_out_kind));
               check_field("tx_byte", 16'(want.tx_byte), 16'(rsp_tx_byte));
               check_field("last_of_run", 16'(want.last), 16'(rsp_last_of_run));
               check_field("reply_field", 16'(want.field), 16'(rsp_reply_field));
               check_field("reply_value", want.value, rsp_reply_value);
               check_field("servo_error", 16'(want.error), 16'(rsp_servo_error));
               check_field("checksum_ok", 16'(want.ok), 16'(rsp_checksum_ok));
            end
         end
         if (req_valid && req_ready)
            forecast_request(req_kind, req_servo_id, req_target_value, req_rx_byte,
                             req_rx_final);
      end
      outstanding <= packet_and_reply_q.size();
   end

endmodule

// ----- sim/servo_packet_engine_unit_tb.sv -----
// Top of the servo packet engine bench: drives requests and register writes,
// randomizes the response stall, and reports the verdict from the checker.
module servo_packet_engine_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import spe_pkg::*;

   localparam int CYCLE_LIMIT    = 400000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int TAIL_CYCLES    = 20;
   localparam int PHASE_REQUESTS = 42;
   localparam int NUM_PHASES     = 8;

   // Kinds the block ignores
   localparam logic [2:0] KIND_UNUSED_LO = 3'd6;
   localparam logic [2:0] KIND_UNUSED_HI = 3'd7;

   logic        clock            = 1'b0;
   logic        reset            = 1'b1;

   logic        req_valid        = 1'b0;
   logic        req_ready;
   logic [2:0]  req_kind         = KIND_WR_POS;
   logic [7:0]  req_servo_id     = '0;
   logic [15:0] req_target_value = '0;
   logic [7:0]  req_rx_byte      = '0;
   logic        req_rx_final     = 1'b0;

   logic        rsp_valid;
   logic        rsp_ready        = 1'b0;
   logic        rsp_out_kind;
   logic [7:0]  rsp_tx_byte;
   logic        rsp_last_of_run;
   logic [1:0]  rsp_reply_field;
   logic [15:0] rsp_reply_value;
   logic [7:0]  rsp_servo_error;
   logic        rsp_checksum_ok;

   logic        csr_valid        = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index        = CSR_CLAMP_ID;
   logic [11:0] csr_data         = '0;

   int          fail_count;
   int          outstanding;

   int          sender_idle_pct    = 0;
   int          receiver_stall_pct = 0;
   int          requests_sent      = 0;
   int          cycle_count        = 0;

   // Current register settings, used to aim targets at the clamp window
   logic [7:0]  cfg_clamp_id = 8'd1;
   logic [11:0] cfg_floor    = 12'd0;
   logic [11:0] cfg_ceiling  = 12'hFFF;

   servo_packet_engine_unit u_dut (.*);

   servo_packet_engine_checker u_checker (.*);

   always #5 clock = ~clock;

   // Stall the response side at the rate of the current phase.
   always @(posedge clock) rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);

   // Abort a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Offer one request and hold it until accepted. Valid stays high on return so
   // back-to-back requests carry no bubble; the next call or drain drops it.
   task automatic send_request(input logic [2:0] kind, input logic [7:0] id,
                               input logic [15:0] target, input logic [7:0] rx,
                               input logic fin);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_kind         <= kind;
      req_servo_id     <= id;
      req_target_value <= target;
      req_rx_byte      <= rx;
      req_rx_final     <= fin;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (kind <= KIND_RX_BYTE) requests_sent++;
   endtask

   // Fill the receive fields with noise; a command ignores them.
   task automatic send_command(input logic [2:0] kind, input logic [7:0] id,
                               input logic [15:0] target);
      send_request(kind, id, target, 8'($urandom), 1'($urandom));
   endtask

   // Mix full-range noise, in-range values, values around the window edges
   // and the clamp limits themselves.
   function automatic logic [15:0] pick_target();
      case ($urandom_range(3))
         0: return 16'($urandom);
         1: return 16'($urandom_range(4095));
         2: return ($urandom_range(1) ? {4'h0, cfg_floor} : {4'h0, cfg_ceiling})
                   + 16'($urandom_range(4)) - 16'd2;
         default: begin
            case ($urandom_range(5))
               0: return 16'd0;
               1: return 16'd4095;
               2: return 16'd4096;
               3: return 16'd1023;
               4: return 16'd1024;
               default: return 16'hFFFF;
            endcase
         end
      endcase
   endfunction

   // Hit the clamped servo half of the time.
   function automatic logic [7:0] pick_servo_id();
      return $urandom_range(1) ? cfg_clamp_id : 8'($urandom);
   endfunction

   task automatic random_command();
      send_command(3'($urandom_range(KIND_WR_POS, KIND_RD_TEMP)), pick_servo_id(),
                   pick_target());
   endtask

   // Send a status packet without header: id, length, error, params, checksum.
   // Keep only the first bytes to make a short packet; optionally corrupt the
   // checksum or slip a command in after the length byte.
   task automatic send_status(input logic [7:0] id, input int nparam, input int keep,
                              input bit bad_sum, input bit interject);
      logic [7:0] body [$];
      logic [7:0] sum;
      logic [7:0] checksum;
      body.push_back(id);
      body.push_back(8'(nparam + 2));
      body.push_back(($urandom_range(2) == 0) ? 8'($urandom) : 8'h00);
      repeat (nparam) body.push_back(8'($urandom));
      if (keep > body.size()) keep = body.size();
      sum = '0;
      // bytes past the frame limit never reach the sum
      for (int i = 0; i < keep && i < MAX_FRAME_BYTES - 1; i++) sum += body[i];
      checksum = ~sum;
      if (bad_sum) checksum ^= 8'($urandom_range(1, 255));
      for (int i = 0; i < keep; i++) begin
         send_request(KIND_RX_BYTE, 8'($urandom), 16'($urandom), body[i], 1'b0);
         if (interject && i == 1) random_command();
      end
      send_request(KIND_RX_BYTE, 8'($urandom), 16'($urandom), checksum, 1'b1);
   endtask

   // Drop valid, wait for every forecast result, then let trailing work settle.
   task automatic drain(input int settle);
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // Hold valid on return so consecutive writes go back to back; the caller drops it.
   task automatic write_register(input logic [1:0] index, input logic [11:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic configure(input logic [7:0] clamp_id, input logic [11:0] lo,
                            input logic [11:0] hi);
      drain(SETTLE_CYCLES);
      write_register(CSR_CLAMP_ID, {4'h0, clamp_id});
      write_register(CSR_FLOOR, lo);
      write_register(CSR_CEILING, hi);
      csr_valid <= 1'b0;
      cfg_clamp_id = clamp_id;
      cfg_floor    = lo;
      cfg_ceiling  = hi;
   endtask

   initial begin
      int         phase;
      int         pick;
      int         phase_target;
      int         nparam;
      logic [2:0] rd_kind;
      logic [7:0] sid;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: window 1000..2000 on servo 7
      configure(8'd7, 12'd1000, 12'd2000);
      send_command(KIND_WR_POS, 8'd7, 16'd0);
      send_command(KIND_WR_POS, 8'd7, 16'hFFFF);
      send_command(KIND_WR_POS, 8'd8, 16'hFFFF);
      send_command(KIND_WR_POS, 8'd0, 16'd4095);
      send_command(KIND_WR_SPEED, 8'd255, 16'hFFFF);
      // unused kinds give nothing back
      send_request(KIND_UNUSED_LO, 8'hFF, 16'hFFFF, 8'hFF, 1'b1);
      send_request(KIND_UNUSED_HI, 8'h00, 16'h0000, 8'h00, 1'b0);
      // short packet with no query outstanding: only the id, then the checksum
      send_status(8'd9, 0, 1, 1'b0, 1'b0);
      send_command(KIND_RD_TEMP, 8'd3, 16'd0);
      send_status(8'd3, 1, 4, 1'b0, 1'b0);
      // rejected reply
      send_command(KIND_RD_SPEED, 8'd254, 16'd0);
      send_status(8'd254, 2, 5, 1'b1, 1'b0);
      send_command(KIND_RD_POS, 8'd0, 16'hFFFF);
      // inverted window: floor wins
      configure(8'd7, 12'd3000, 12'd1000);
      send_command(KIND_WR_POS, 8'd7, 16'd500);
      send_command(KIND_WR_POS, 8'd7, 16'hFFFF);

      // Random phases: rotate register settings and idling patterns
      for (phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0: configure(8'd1, 12'd0, 12'hFFF);
            1: configure(8'd0, 12'hFFF, 12'd0);
            2: configure(8'd255, 12'd0, 12'd0);
            3: configure(8'd255, 12'hFFF, 12'hFFF);
            default: configure(8'($urandom), 12'($urandom), 12'($urandom));
         endcase
         case (phase % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 67; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 67; end
            default: begin sender_idle_pct = 37; receiver_stall_pct = 37; end
         endcase
         phase_target = requests_sent + PHASE_REQUESTS;
         // one overlong packet whose excess bytes must be dropped
         if (phase == 3)
            send_status(pick_servo_id(), MAX_FRAME_BYTES + 4, MAX_FRAME_BYTES + 7,
                        1'b0, 1'b0);
         while (requests_sent < phase_target) begin
            pick = $urandom_range(99);
            if (pick < 25) begin
               random_command();
            end else if (pick < 60) begin
               // read: query, then a matching status packet, now and then corrupted or interrupted
               rd_kind = 3'($urandom_range(KIND_RD_POS, KIND_RD_TEMP));
               sid     = pick_servo_id();
               send_command(rd_kind, sid, pick_target());
               nparam = (rd_kind == KIND_RD_TEMP) ? 1 : 2;
               send_status(sid, nparam, nparam + 3, $urandom_range(9) == 0,
                           $urandom_range(7) == 0);
            end else if (pick < 75) begin
               // arbitrary packet, possibly short, corrupted or interrupted
               nparam = $urandom_range(4);
               send_status(8'($urandom), nparam, $urandom_range(1, nparam + 3),
                           $urandom_range(3) == 0, $urandom_range(2) == 0);
            end else if (pick < 90) begin
               repeat ($urandom_range(1, 4))
                  send_request(KIND_RX_BYTE, 8'($urandom), 16'($urandom),
                               8'($urandom), 1'($urandom));
            end else begin
               send_request(3'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI)),
                            8'($urandom), 16'($urandom), 8'($urandom), 1'($urandom));
            end
         end
      end

      drain(TAIL_CYCLES);
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
